### hdl/zas_pkg.sv
// Shared types and constants for the zone alarm scheduler.
package zas_pkg;

    // Number of alarm zones (1 to 4)
    localparam int ZONE_COUNT = 4;
    // Zones that fit the fixed-width result vectors
    localparam int OUT_ZONES  = (ZONE_COUNT < 4) ? ZONE_COUNT : 4;

    localparam int TIME_W = 17;
    localparam logic [TIME_W-1:0] DAY_SECONDS = 17'd86400;

    // Command codes
    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_TRIGGER     = 3'd1,
        CMD_HUSH_ALL    = 3'd2,
        CMD_TOGGLE_ALL  = 3'd3,
        CMD_ENABLE_ALL  = 3'd4,
        CMD_DISABLE_ALL = 3'd5,
        CMD_SET_STATUS  = 3'd6,
        CMD_SET_WINDOW  = 3'd7
    } t_cmd;

    // Zone status codes
    typedef enum logic [1:0] {
        ST_DISABLED  = 2'd0,
        ST_ENABLED   = 2'd1,
        ST_TRIGGERED = 2'd2
    } t_status;

    // Input item
    typedef struct packed {
        t_cmd              cmd;
        logic [1:0]        zone;
        logic [1:0]        new_status;
        logic [TIME_W-1:0] win_open;
        logic [TIME_W-1:0] win_close;
        logic [TIME_W-1:0] time_seconds;
        logic              flash_phase;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0]        status_vector;
        logic [3:0]        led_vector;
        logic [TIME_W-1:0] time_of_day;
        logic [3:0]        window_set_vector;
    } t_out_item;

    // Per-zone command control from the top level
    typedef struct packed {
        logic              fire;
        t_cmd              cmd;
        logic              sel;
        logic [1:0]        new_status;
        logic [TIME_W-1:0] win_open;
        logic [TIME_W-1:0] win_close;
        logic [TIME_W-1:0] tod;
        logic              all_enabled;
    } t_zone_ctl;

endpackage

### hdl/zone_alarm_scheduler.sv
// Top level of the zone alarm scheduler: input register, zone array, result register.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one command (t_in_item) per
//   transfer; output channel o_out_valid / i_out_stall returns exactly one
//   result (t_out_item) per command, in order.
//   A command lands in the input register, is applied to all zones in
//   parallel when it moves on, and its result is written to the output
//   register at the end of that cycle, where o_out_valid rises with it.
//   Throughput is one command per cycle while the receiver does not stall;
//   a new command is taken while the previous result waits in the output
//   register.
//   When the receiver stalls, the result holds in the output register and
//   the next command holds in the input register; o_in_stall rises only
//   when both are full.
//   Reset (i_rst_n low, synchronous) sets every zone enabled, clears all
//   windows and window-set flags, clears the stored time and empties both
//   registers. No clearing pass is needed.
module zone_alarm_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  zas_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output zas_pkg::t_out_item o_out
);

    logic                       r_in_valid;
    zas_pkg::t_in_item          r_in;
    logic                       r_out_valid;
    logic                       n_out_valid;
    zas_pkg::t_out_item         r_out;
    zas_pkg::t_out_item         n_out;
    logic [zas_pkg::TIME_W-1:0] r_last_time;
    logic [zas_pkg::TIME_W-1:0] w_wrapped;
    logic [zas_pkg::TIME_W-1:0] w_tod;
    logic                       w_advance;
    logic                       w_accept;
    logic                       w_all_enabled;
    zas_pkg::t_zone_ctl         w_ctl        [zas_pkg::ZONE_COUNT];
    zas_pkg::t_status           w_status     [zas_pkg::ZONE_COUNT];
    zas_pkg::t_status           w_status_nxt [zas_pkg::ZONE_COUNT];
    logic                       w_set_nxt    [zas_pkg::ZONE_COUNT];

    // Handshake: the held command moves on when the result slot is free
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
    end

    // Time of day: raw value stays below twice a day, so one subtract wraps it
    assign w_wrapped = (r_in.time_seconds >= zas_pkg::DAY_SECONDS)
                     ? r_in.time_seconds - zas_pkg::DAY_SECONDS
                     : r_in.time_seconds;
    assign w_tod     = (r_in.cmd == zas_pkg::CMD_TICK) ? w_wrapped : r_last_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
        end else if (w_advance) begin
            r_last_time <= w_tod;
        end
    end

    // Toggle needs to know whether every zone is enabled
    always_comb begin
        w_all_enabled = 1'b1;
        for (int k = 0; k < zas_pkg::ZONE_COUNT; k++) begin
            w_all_enabled = w_all_enabled && (w_status[k] == zas_pkg::ST_ENABLED);
        end
    end

    // Zone array
    for (genvar g = 0; g < zas_pkg::ZONE_COUNT; g++) begin : g_zone
        always_comb begin
            w_ctl[g].fire        = w_advance;
            w_ctl[g].cmd         = r_in.cmd;
            w_ctl[g].sel         = (int'(r_in.zone) == g);
            w_ctl[g].new_status  = r_in.new_status;
            w_ctl[g].win_open    = r_in.win_open;
            w_ctl[g].win_close   = r_in.win_close;
            w_ctl[g].tod         = w_tod;
            w_ctl[g].all_enabled = w_all_enabled;
        end

        zas_zone u_zone (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_ctl             (w_ctl[g]),
            .o_status          (w_status[g]),
            .o_status_next     (w_status_nxt[g]),
            .o_window_set_next (w_set_nxt[g])
        );
    end

    // Result packing from the post-command zone state
    always_comb begin
        n_out = '0;
        n_out.time_of_day = w_tod;
        for (int k = 0; k < zas_pkg::OUT_ZONES; k++) begin
            n_out.status_vector[2*k +: 2] = w_status_nxt[k];
            n_out.window_set_vector[k]    = w_set_nxt[k];
            if (w_status_nxt[k] == zas_pkg::ST_TRIGGERED) begin
                n_out.led_vector[k] = r_in.flash_phase;
            end else begin
                n_out.led_vector[k] = (w_status_nxt[k] == zas_pkg::ST_ENABLED);
            end
        end
    end

    // Result register
    always_comb begin
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Stored time is always wrapped into one day
    a_time_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_time < zas_pkg::DAY_SECONDS)
        else $error("stored time not wrapped");

    // A moved command always produces a valid result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result missing after command moved");

    // Input stall only when a command is held and the result slot is busy
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("spurious input stall");

    // A held command is not dropped while stalled
    a_hold_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("held command lost");

    // Zone 0's status code in the result never carries the unused code
    a_no_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status_vector[1:0] != 2'b11))
        else $error("invalid status code in result");

endmodule

### hdl/zas_zone.sv
// One alarm zone: status, daily window and window-set flag with update logic.
module zas_zone (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  zas_pkg::t_zone_ctl          i_ctl,
    output zas_pkg::t_status            o_status,
    output zas_pkg::t_status            o_status_next,
    output logic                        o_window_set_next
);

    zas_pkg::t_status                   r_status;
    zas_pkg::t_status                   n_status;
    logic [zas_pkg::TIME_W-1:0]         r_win_start;
    logic [zas_pkg::TIME_W-1:0]         r_win_end;
    logic                               r_win_set;
    logic                               n_win_set;
    logic                               w_sched;
    logic                               w_inside;

    // Window match; start above end wraps past midnight
    always_comb begin
        w_sched = (r_win_start != r_win_end);
        if (r_win_start > r_win_end) begin
            w_inside = (i_ctl.tod >= r_win_start) || (i_ctl.tod < r_win_end);
        end else begin
            w_inside = (i_ctl.tod >= r_win_start) && (i_ctl.tod < r_win_end);
        end
    end

    // Next status for the current command
    always_comb begin
        n_status = r_status;
        unique case (i_ctl.cmd)
            zas_pkg::CMD_TICK: begin
                if (r_status != zas_pkg::ST_TRIGGERED && w_sched) begin
                    n_status = w_inside ? zas_pkg::ST_ENABLED : zas_pkg::ST_DISABLED;
                end
            end
            zas_pkg::CMD_TRIGGER: begin
                if (i_ctl.sel && r_status == zas_pkg::ST_ENABLED) begin
                    n_status = zas_pkg::ST_TRIGGERED;
                end
            end
            zas_pkg::CMD_HUSH_ALL: begin
                if (r_status == zas_pkg::ST_TRIGGERED) begin
                    n_status = zas_pkg::ST_ENABLED;
                end
            end
            zas_pkg::CMD_TOGGLE_ALL: begin
                n_status = i_ctl.all_enabled ? zas_pkg::ST_DISABLED : zas_pkg::ST_ENABLED;
            end
            zas_pkg::CMD_ENABLE_ALL:  n_status = zas_pkg::ST_ENABLED;
            zas_pkg::CMD_DISABLE_ALL: n_status = zas_pkg::ST_DISABLED;
            zas_pkg::CMD_SET_STATUS: begin
                // status code three is ignored
                if (i_ctl.sel && i_ctl.new_status <= 2'(zas_pkg::ST_TRIGGERED)) begin
                    n_status = zas_pkg::t_status'(i_ctl.new_status);
                end
            end
            zas_pkg::CMD_SET_WINDOW: n_status = r_status;
            default:                 n_status = r_status;
        endcase
    end

    assign n_win_set = r_win_set
                     | (i_ctl.sel && i_ctl.cmd == zas_pkg::CMD_SET_WINDOW);

    // Zone state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= zas_pkg::ST_ENABLED;
            r_win_start <= '0;
            r_win_end   <= '0;
            r_win_set   <= 1'b0;
        end else if (i_ctl.fire) begin
            r_status  <= n_status;
            r_win_set <= n_win_set;
            if (i_ctl.sel && i_ctl.cmd == zas_pkg::CMD_SET_WINDOW) begin
                r_win_start <= i_ctl.win_open;
                r_win_end   <= i_ctl.win_close;
            end
        end
    end

    assign o_status          = r_status;
    assign o_status_next     = n_status;
    assign o_window_set_next = n_win_set;

endmodule
